### hdl/sopt_pkg.sv
`default_nettype none

package sopt_pkg;

  // Query and root widths
  localparam int VALUE_W = 40;
  localparam int ROOT_W  = VALUE_W / 2;
  // The remainder never exceeds twice the partial root
  localparam int REM_W   = ROOT_W + 1;
  // One root cell per bit pair of the value
  localparam int N_CELLS = VALUE_W / 2;

  // Composite bitmap: one bit per candidate root
  localparam int MAP_AW    = ROOT_W;
  localparam int MAP_DEPTH = 1 << MAP_AW;
  // Sieve base runs while base*base < MAP_DEPTH
  localparam int SIEVE_IW  = MAP_AW / 2 + 1;

  // Payload that moves from one root cell to the next
  typedef struct packed {
    logic [VALUE_W-1:0] val;   // unconsumed bit pairs, MSB aligned
    logic [REM_W-1:0]   rem;   // running remainder
    logic [ROOT_W-1:0]  root;  // partial root
  } sopt_stage_t;

endpackage

`default_nettype wire

### hdl/sopt_root_cell.sv
`default_nettype none

module sopt_root_cell
  import sopt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        up_valid,
  output logic             up_ready,
  input  wire sopt_stage_t up_stage,
  output logic             dn_valid,
  input  wire logic        dn_ready,
  output sopt_stage_t      dn_stage
);

  logic        valid_r;
  sopt_stage_t stage_r;
  sopt_stage_t stage_nxt;

  logic [1:0]       pair;
  logic [REM_W+1:0] acc;
  logic [REM_W+2:0] diff;
  logic             borrow;

  // One restoring step: try to subtract 4*root+1 from the shifted remainder
  always_comb begin
    pair   = up_stage.val[VALUE_W-1 -: 2];
    acc    = {up_stage.rem, pair};
    diff   = {1'b0, acc} - {2'b00, up_stage.root, 2'b01};
    borrow = diff[REM_W+2];
    stage_nxt.val  = up_stage.val << 2;
    stage_nxt.rem  = borrow ? acc[REM_W-1:0] : diff[REM_W-1:0];
    stage_nxt.root = {up_stage.root[ROOT_W-2:0], ~borrow};
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_stage = stage_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/sopt_sieve.sv
`default_nettype none

module sopt_sieve
  import sopt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  output logic                   done,
  input  wire logic              lk_en,
  input  wire logic [MAP_AW-1:0] lk_addr,
  output logic                   lk_composite
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_PROBE,
    ST_CHECK,
    ST_MARK,
    ST_DONE
  } sieve_state_t;

  sieve_state_t        state_r,   state_nxt;
  logic [MAP_AW-1:0]   clr_r,     clr_nxt;
  logic [SIEVE_IW-1:0] base_r,    base_nxt;
  logic [MAP_AW:0]     mult_r,    mult_nxt;

  logic                map_mem [0:MAP_DEPTH-1];
  logic                rd_data_r;
  logic                rd_en;
  logic [MAP_AW-1:0]   rd_addr;
  logic                wr_en;
  logic [MAP_AW-1:0]   wr_addr;
  logic                wr_data;

  logic [2*SIEVE_IW-1:0] base_sq;
  logic [MAP_AW:0]       mult_step;

  assign base_sq   = base_r * base_r;
  assign mult_step = mult_r + (MAP_AW+1)'(base_r);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    base_nxt  = base_r;
    mult_nxt  = mult_r;
    wr_en     = 1'b0;
    wr_addr   = clr_r;
    wr_data   = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == {MAP_AW{1'b1}}) begin
          state_nxt = ST_PROBE;
          base_nxt  = SIEVE_IW'(2);
        end
      end
      ST_PROBE: begin
        if (base_sq >= (2*SIEVE_IW)'(MAP_DEPTH)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (rd_data_r) begin
          base_nxt  = base_r + 1'b1;
          state_nxt = ST_PROBE;
        end else begin
          mult_nxt  = base_sq[MAP_AW:0];
          state_nxt = ST_MARK;
        end
      end
      ST_MARK: begin
        wr_en    = 1'b1;
        wr_addr  = mult_r[MAP_AW-1:0];
        wr_data  = 1'b1;
        mult_nxt = mult_step;
        if (mult_step[MAP_AW]) begin
          base_nxt  = base_r + 1'b1;
          state_nxt = ST_PROBE;
        end
      end
      ST_DONE: begin
        state_nxt = ST_DONE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Read port serves the sieve probes until done, then the query lookups
  assign rd_en   = (state_r == ST_DONE) ? lk_en : (state_r == ST_PROBE);
  assign rd_addr = (state_r == ST_DONE) ? lk_addr : MAP_AW'(base_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      base_r  <= SIEVE_IW'(2);
      mult_r  <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      base_r  <= base_nxt;
      mult_r  <= mult_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= map_mem[rd_addr];
    end
  end

  assign done         = (state_r == ST_DONE);
  assign lk_composite = rd_data_r;

  a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |=> state_r == ST_DONE)
    else $error("sieve left done state");

  a_mark_above_three: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MARK |-> mult_r >= (MAP_AW+1)'(4))
    else $error("sieve marked root below four");

  a_mark_base_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MARK |-> base_r >= SIEVE_IW'(2))
    else $error("sieve marking with base below two");

endmodule

`default_nettype wire

### hdl/square_of_prime_test_core.sv
`default_nettype none

// Square-of-prime test: each request carries a 40-bit unsigned value and
// returns one bit, high when the value is p*p for a prime p (equivalently,
// the value has exactly three divisors). After reset the block builds a
// composite bitmap of all roots below 2^20 with a sieve of Eratosthenes:
// a clearing pass over every bitmap entry, then roughly 2.2 million
// marking writes, during which in_ready stays low. Once the sieve is done
// the block takes one request per cycle unless out_ready holds it back:
// a row of 20 square-root cells, one bit pair of the value each, feeds a
// single bitmap lookup register, and the one-read-per-cycle bitmap port
// sets the rate at one request per cycle. Each cell stage holds its
// request on its own, so requests keep entering while a finished answer
// waits on out_ready, until every cell holds one.
module square_of_prime_test_core
  import sopt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [VALUE_W-1:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_is_square_of_prime
);

  sopt_stage_t stage [0:N_CELLS];
  logic        vld   [0:N_CELLS];
  logic        rdy   [0:N_CELLS];

  logic              sieve_done;
  logic              lk_composite;
  logic              m_ready;
  logic              m_valid_r;
  logic              m_ok_r;
  logic              root_ok;
  sopt_stage_t       last;

  sopt_sieve u_sieve (
    .clk          (clk),
    .rst_n        (rst_n),
    .done         (sieve_done),
    .lk_en        (m_ready),
    .lk_addr      (stage[N_CELLS].root),
    .lk_composite (lk_composite)
  );

  // Hold off requests until the bitmap is complete
  assign in_ready = rdy[0] && sieve_done;
  assign vld[0]   = in_valid && sieve_done;

  always_comb begin
    stage[0].val  = in_value;
    stage[0].rem  = '0;
    stage[0].root = '0;
  end

  // Root cells: each consumes the top bit pair and passes the rest down
  for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
    sopt_root_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld[k]),
      .up_ready (rdy[k]),
      .up_stage (stage[k]),
      .dn_valid (vld[k+1]),
      .dn_ready (rdy[k+1]),
      .dn_stage (stage[k+1])
    );
  end

  // Zero remainder means the value is an exact square; roots 0 and 1 never
  // answer yes. Every root fits the bitmap, so no range check is needed.
  assign last    = stage[N_CELLS];
  assign root_ok = (last.rem == '0) && (|last.root[ROOT_W-1:1]);

  // Lookup stage doubles as the output register: the bitmap read data and
  // the root check advance together and hold together on a stall.
  assign m_ready      = !m_valid_r || out_ready;
  assign rdy[N_CELLS] = m_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (m_ready) begin
      m_valid_r <= vld[N_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (m_ready && vld[N_CELLS]) begin
      m_ok_r <= root_ok;
    end
  end

  assign out_valid              = m_valid_r;
  assign out_is_square_of_prime = m_ok_r && !lk_composite;

  a_no_request_before_sieve: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> sieve_done)
    else $error("request accepted before sieve finished");

  a_quiet_output_during_sieve: assert property (@(posedge clk) disable iff (!rst_n)
    !sieve_done |-> !out_valid)
    else $error("result presented during sieve");

  a_empty_chain_during_sieve: assert property (@(posedge clk) disable iff (!rst_n)
    !sieve_done |-> !vld[N_CELLS])
    else $error("root chain busy during sieve");

endmodule

`default_nettype wire

### sim/square_of_prime_test_core_test.sv
`timescale 1ns / 100ps

// Every request is checked against an independent predictor. The predictor
// takes an exact floor root of the value one bit at a time, then tests that
// root for primality by trial division. The block's sieve is never consulted.
module square_of_prime_test_core_test
  import sopt_pkg::*;
();

  localparam int ROOT_MAX      = (1 << ROOT_W) - 1;
  // Sizes the final wait for any stray extra result
  localparam int PIPE_LATENCY  = 21;
  localparam int RANDOM_ITEMS  = 1450;
  localparam int RANDOM_PHASES = 10;
  localparam int MAX_SHOWN     = 10;

  // One accepted request together with the verdict predicted for it
  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               verdict;
  } verdict_req_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [VALUE_W-1:0] in_value;
  logic               out_valid;
  logic               out_ready;
  logic               out_is_square_of_prime;

  verdict_req_t pending_verdicts[$];
  int           err_cnt;
  // Enable random gaps on the request side and random stalls on the result side
  bit           tx_idle;
  bit           rx_idle;
  // Largest prime whose square still fits in VALUE_W bits
  longint unsigned largest_prime_root;

  square_of_prime_test_core u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_value               (in_value),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_is_square_of_prime (out_is_square_of_prime)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Trial division. Roots stay below 2^20, so the loop runs at most about
  // a thousand times.
  function automatic bit is_prime_root(input longint unsigned root);
    longint unsigned divisor;
    if (root < 2) return 1'b0;
    divisor = 2;
    while (divisor * divisor <= root) begin
      if (root % divisor == 0) return 1'b0;
      divisor++;
    end
    return 1'b1;
  endfunction

  // Build the floor root greedily from the top bit down. Keep a bit when the
  // square of the trial root still fits under the value. The verdict is yes
  // only for an exact square whose root is prime. That excludes roots 0
  // and 1 as well as non-squares.
  function automatic logic square_of_prime(input logic [VALUE_W-1:0] value);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= value) root = trial;
    end
    return (root * root == value) && is_prime_root(root);
  endfunction

  // Random request mix:
  // - mostly squares of primes and squares of arbitrary roots across all root sizes
  // - then near misses one off a square
  // - then full-width noise and small values
  function automatic logic [VALUE_W-1:0] pick_random_value();
    longint unsigned root;
    longint unsigned value;
    int              kind;
    kind = $urandom_range(0, 9);
    root = $urandom_range(0, (1 << $urandom_range(1, ROOT_W)) - 1);
    if (kind <= 3) begin
      // Advance to the next prime and clamp so the square still fits
      if (root > largest_prime_root) root = largest_prime_root;
      while (!is_prime_root(root)) root++;
      value = root * root;
    end else if (kind <= 5) begin
      value = root * root;
    end else if (kind == 6) begin
      value = root * root;
      if (value == 0 || $urandom_range(0, 1) == 1) value = value + 1;
      else value = value - 1;
    end else if (kind <= 8) begin
      value = (longint'($urandom_range(0, 255)) << 32) | longint'($urandom());
    end else begin
      value = $urandom_range(0, 64);
    end
    return value[VALUE_W-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------

  // Draw the gap first. Drop valid only when a gap is taken, so valid never
  // gets two updates in one step between back-to-back requests. Hold valid
  // and the value until the handshake, then record the expected verdict.
  task automatic send_value(input logic [VALUE_W-1:0] value);
    int           gap;
    verdict_req_t accepted;
    gap = tx_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    accepted.value   = value;
    accepted.verdict = square_of_prime(value);
    pending_verdicts.insert(pending_verdicts.size(), accepted);
  endtask

  // Drop valid and hold off until every pending verdict has come back
  task automatic wait_for_verdicts();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
  endtask

  // ---------------------------------------------------------------------
  // Result side: when rx_idle is set, drop out_ready for a random stall before each result
  // ---------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = rx_idle ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Compare each accepted result with the oldest pending verdict
  always @(posedge clk) begin : verdict_check
    verdict_req_t exp_req;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_SHOWN)
          $display("unexpected result %0b with no request pending",
                   out_is_square_of_prime);
      end else begin
        exp_req = pending_verdicts.pop_front();
        if (out_is_square_of_prime !== exp_req.verdict) begin
          err_cnt++;
          if (err_cnt <= MAX_SHOWN)
            $display("value %0d: expected %0b, got %0b",
                     exp_req.value, exp_req.verdict, out_is_square_of_prime);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Roots zero and one, the smallest prime squares, composite squares,
  // and non-squares next to them
  task automatic test_small_roots();
    send_value(40'd0);
    send_value(40'd1);
    send_value(40'd2);
    send_value(40'd3);
    send_value(40'd4);
    send_value(40'd5);
    send_value(40'd8);
    send_value(40'd9);
    send_value(40'd15);
    send_value(40'd16);
    send_value(40'd25);
    send_value(40'd49);
    send_value(40'd121);
  endtask

  // Cover the top of the value range:
  // - the largest prime square and its neighbors
  // - the largest root squared, which is composite
  // - powers of two, and all ones
  task automatic test_wide_values();
    longint unsigned lp_sq;
    lp_sq = largest_prime_root * largest_prime_root;
    send_value(40'h40_0000_0000);
    send_value(40'h80_0000_0000);
    send_value(VALUE_W'(longint'(ROOT_MAX) * longint'(ROOT_MAX)));
    send_value(VALUE_W'(lp_sq - 1));
    send_value(VALUE_W'(lp_sq));
    send_value(VALUE_W'(lp_sq + 1));
    send_value({VALUE_W{1'b1}});
  endtask

  // Run the random mix in phases. Cycle through gaps on both sides, neither
  // side, requests only, and results only. Drain fully after each phase.
  task automatic test_random_values();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      tx_idle = (phase % 4 == 0) || (phase % 4 == 2);
      rx_idle = (phase % 4 == 0) || (phase % 4 == 3);
      for (int n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++)
        send_value(pick_random_value());
      wait_for_verdicts();
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_value = '0;
    err_cnt  = 0;
    tx_idle  = 1'b1;
    rx_idle  = 1'b1;

    largest_prime_root = ROOT_MAX;
    while (!is_prime_root(largest_prime_root)) largest_prime_root--;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // The first request waits out the sieve: in_ready stays low until it ends
    test_small_roots();
    wait_for_verdicts();
    test_wide_values();
    wait_for_verdicts();
    test_random_values();

    // Give any stray extra result time to show up
    wait_for_verdicts();
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS square_of_prime_test_core");
    end else begin
      $display("FAIL square_of_prime_test_core");
    end
    $finish;
  end

  // The sieve after reset dominates the run time; this timeout leaves ample
  // margin over the slowest correct run.
  initial begin
    #30_000_000;
    $display("FAIL square_of_prime_test_core");
    $finish;
  end

endmodule
